FILE: design/cbmf_pkg.sv
package cbmf_pkg;

    // default sizes of the image store and the window
    localparam int DEF_MAX_SIDE   = 64;
    localparam int DEF_MAX_RADIUS = 7;

    // field widths
    localparam int ROW_W     = 6;
    localparam int PIX_W     = 8;
    localparam int OUT_W     = 8;
    localparam int SIDE_W    = 7;
    localparam int CRD_W     = 7;
    localparam int RAD_W     = 4;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int QB_W      = 3;

    // command queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'b1;

    // action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [1:0] {
        K_WRITE,
        K_QUERY,
        K_OUTSIDE
    } t_kind;

    // for a write, row_lo and col_lo hold the pixel position
    typedef struct packed {
        t_kind              kind;
        logic [CRD_W-1:0]   row_lo;
        logic [CRD_W-1:0]   row_hi;
        logic [CRD_W-1:0]   col_lo;
        logic [CRD_W-1:0]   col_hi;
        logic [PIX_W-1:0]   pixel;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_DIV,
        S_OUT
    } t_state;

endpackage

FILE: design/cbmf_in_if.sv
interface cbmf_in_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [cbmf_pkg::ROW_W-1:0]  row;
    logic [cbmf_pkg::ROW_W-1:0]  col;
    logic [cbmf_pkg::PIX_W-1:0]  pixel;

    modport source (output valid, output action, output row, output col, output pixel,
                    input ready);
    modport sink   (input valid, input action, input row, input col, input pixel,
                    output ready);
endinterface

FILE: design/cbmf_out_if.sv
interface cbmf_out_if;
    logic                        valid;
    logic                        ready;
    logic [cbmf_pkg::OUT_W-1:0]  mean_value;
    logic [cbmf_pkg::OUT_W-1:0]  window_count;

    modport source (output valid, output mean_value, output window_count, input ready);
    modport sink   (input valid, input mean_value, input window_count, output ready);
endinterface

FILE: design/cbmf_front.sv
module cbmf_front #(
    parameter int MAX_SIDE   = cbmf_pkg::DEF_MAX_SIDE,
    parameter int MAX_RADIUS = cbmf_pkg::DEF_MAX_RADIUS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cbmf_in_if.sink                         i_in,
    input  logic                            i_cfg_we,
    input  logic [cbmf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cbmf_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_q_ready,
    output logic                            o_push,
    output cbmf_pkg::t_cmd                  o_cmd
);
    import cbmf_pkg::*;

    logic [SIDE_W-1:0] r_side;
    logic [2:0]        r_radius;
    logic [SIDE_W-1:0] eff_side;
    logic [RAD_W-1:0]  eff_rad;
    logic [CRD_W-1:0]  row_x, col_x, row_top, col_top, side_x, rad_x;
    logic              in_image;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side   <= SIDE_W'(DEF_MAX_SIDE);
            r_radius <= 3'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SIDE:   r_side   <= i_cfg_data[SIDE_W-1:0];
                CFG_RADIUS: r_radius <= i_cfg_data[2:0];
                default:    ;
            endcase
        end
    end

    // clamp the registers to what the store and the window allow
    always_comb begin
        if (r_side == '0) begin
            eff_side = SIDE_W'(1);
        end else if (32'(r_side) > MAX_SIDE) begin
            eff_side = SIDE_W'(MAX_SIDE);
        end else begin
            eff_side = r_side;
        end
        if (32'(r_radius) > MAX_RADIUS) begin
            eff_rad = RAD_W'(MAX_RADIUS);
        end else begin
            eff_rad = RAD_W'(r_radius);
        end
    end

    assign row_x    = CRD_W'(i_in.row);
    assign col_x    = CRD_W'(i_in.col);
    assign side_x   = CRD_W'(eff_side);
    assign rad_x    = CRD_W'(eff_rad);
    assign row_top  = row_x + rad_x;
    assign col_top  = col_x + rad_x;
    assign in_image = (row_x < side_x) && (col_x < side_x);

    // clipped window bounds
    always_comb begin
        o_cmd.pixel  = i_in.pixel;
        o_cmd.row_lo = (row_x >= rad_x) ? row_x - rad_x : '0;
        o_cmd.col_lo = (col_x >= rad_x) ? col_x - rad_x : '0;
        o_cmd.row_hi = (row_top >= side_x) ? side_x - 1'b1 : row_top;
        o_cmd.col_hi = (col_top >= side_x) ? side_x - 1'b1 : col_top;
        if (i_in.action == ACT_WRITE) begin
            o_cmd.kind   = K_WRITE;
            o_cmd.row_lo = row_x;
            o_cmd.col_lo = col_x;
        end else if (in_image) begin
            o_cmd.kind = K_QUERY;
        end else begin
            o_cmd.kind = K_OUTSIDE;
        end
    end

    // writes outside the image are taken and dropped
    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid && i_q_ready && (in_image || (i_in.action == ACT_QUERY));

endmodule

FILE: design/cbmf_queue.sv
module cbmf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cbmf_pkg::t_cmd  i_cmd,
    output logic            o_ready,
    output logic            o_valid,
    output cbmf_pkg::t_cmd  o_cmd,
    input  logic            i_pop
);
    import cbmf_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, r_rp;
    logic [Q_PTR_W:0]   r_cnt;
    logic               do_push, do_pop;

    assign o_ready = (r_cnt != (Q_PTR_W+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

FILE: design/cbmf_back.sv
module cbmf_back #(
    parameter int MAX_SIDE   = cbmf_pkg::DEF_MAX_SIDE,
    parameter int MAX_RADIUS = cbmf_pkg::DEF_MAX_RADIUS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  cbmf_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    cbmf_out_if.source      o_out
);
    import cbmf_pkg::*;

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)+1);
    localparam int SUM_W = CNT_W + PIX_W;

    logic [PIX_W-1:0] mem [DEPTH];

    t_state           r_state, n_state;
    logic [CRD_W-1:0] r_r, n_r, r_c, n_c, r_c_lo, n_c_lo, r_c_hi, n_c_hi, r_r_hi, n_r_hi;
    logic             r_rd_vld;
    logic [PIX_W-1:0] r_rd_data;
    logic [SUM_W-1:0] r_sum, n_sum, trial;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [OUT_W-1:0] r_quo, n_quo;
    logic [QB_W-1:0]  r_bit, n_bit;
    logic             r_out_valid, n_out_valid;
    logic [OUT_W-1:0] r_out_mean, n_out_mean, r_out_cnt, n_out_cnt;

    logic             slot_free, last, wr_en;
    logic [AW-1:0]    rd_addr, wr_addr;

    assign slot_free = !r_out_valid || o_out.ready;
    assign last      = (r_c == r_c_hi) && (r_r == r_r_hi);
    assign wr_en     = (r_state == S_IDLE) && i_valid && (i_cmd.kind == K_WRITE);
    assign rd_addr   = AW'(32'(r_r) * MAX_SIDE + 32'(r_c));
    assign wr_addr   = AW'(32'(i_cmd.row_lo) * MAX_SIDE + 32'(i_cmd.col_lo));
    assign trial     = SUM_W'(r_cnt) << r_bit;

    // pixel store, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_cmd.pixel;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid && (i_cmd.kind == K_QUERY)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (last) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: n_state = S_DIV;
            S_DIV: begin
                if (r_bit == '0) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        n_r         = r_r;
        n_c         = r_c;
        n_c_lo      = r_c_lo;
        n_c_hi      = r_c_hi;
        n_r_hi      = r_r_hi;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_quo       = r_quo;
        n_bit       = r_bit;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_mean  = r_out_mean;
        n_out_cnt   = r_out_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_cmd.kind)
                        K_QUERY: begin
                            o_pop  = 1'b1;
                            n_r    = i_cmd.row_lo;
                            n_c    = i_cmd.col_lo;
                            n_c_lo = i_cmd.col_lo;
                            n_c_hi = i_cmd.col_hi;
                            n_r_hi = i_cmd.row_hi;
                            n_sum  = '0;
                            n_cnt  = '0;
                        end
                        K_OUTSIDE: begin
                            if (slot_free) begin
                                o_pop       = 1'b1;
                                n_out_valid = 1'b1;
                                n_out_mean  = '0;
                                n_out_cnt   = '0;
                            end
                        end
                        default: o_pop = 1'b1;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_rd_vld) begin
                    n_sum = r_sum + SUM_W'(r_rd_data);
                    n_cnt = r_cnt + 1'b1;
                end
                if (r_c == r_c_hi) begin
                    n_c = r_c_lo;
                    n_r = r_r + 1'b1;
                end else begin
                    n_c = r_c + 1'b1;
                end
            end
            S_TAIL: begin
                n_sum = r_sum + SUM_W'(r_rd_data);
                n_cnt = r_cnt + 1'b1;
                n_quo = '0;
                n_bit = QB_W'(OUT_W - 1);
            end
            S_DIV: begin
                // restoring division, the sum register holds the remainder
                if (r_sum >= trial) begin
                    n_sum        = r_sum - trial;
                    n_quo[r_bit] = 1'b1;
                end
                n_bit = r_bit - 1'b1;
            end
            S_OUT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_mean  = r_quo;
                    n_out_cnt   = OUT_W'(r_cnt);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_vld    <= (r_state == S_SCAN);
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r        <= n_r;
        r_c        <= n_c;
        r_c_lo     <= n_c_lo;
        r_c_hi     <= n_c_hi;
        r_r_hi     <= n_r_hi;
        r_sum      <= n_sum;
        r_cnt      <= n_cnt;
        r_quo      <= n_quo;
        r_bit      <= n_bit;
        r_out_mean <= n_out_mean;
        r_out_cnt  <= n_out_cnt;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.mean_value   = r_out_mean;
    assign o_out.window_count = r_out_cnt;

endmodule

FILE: design/clipped_box_mean_filter.sv
// order: with the back idle a write goes through the command queue into the store;
// a query result follows the scan of its N in-image window pixels (<= 225) and the division
// throughput: one write a cycle while the back is idle; the back runs one query at a time,
// paced by the single store read port (one pixel a cycle) and the 8-step division
// reset: side 64, radius 1, command queue and result register empty;
// the pixel store is not cleared
module clipped_box_mean_filter #(
    parameter int MAX_SIDE   = cbmf_pkg::DEF_MAX_SIDE,
    parameter int MAX_RADIUS = cbmf_pkg::DEF_MAX_RADIUS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cbmf_in_if.sink                         i_in,
    cbmf_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [cbmf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cbmf_pkg::CFG_W-1:0]      i_cfg_data
);
    import cbmf_pkg::*;

    // front to queue
    logic q_ready;
    logic push;
    t_cmd push_cmd;

    // queue to back
    logic q_valid;
    logic pop;
    t_cmd pop_cmd;

    // front: holds the registers, clamps them, classifies each transfer
    // and clips the window to the image before it is queued
    cbmf_front #(
        .MAX_SIDE   (MAX_SIDE),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_ready  (q_ready),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // two-entry queue lets the front buffer up to two commands while a query runs
    cbmf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (pop_cmd),
        .i_pop   (pop)
    );

    // back: pixel store, window scan, divider and result register
    cbmf_back #(
        .MAX_SIDE   (MAX_SIDE),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (pop_cmd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

`ifndef SYNTH
    // nothing is pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> q_ready)
        else $error("push into full command queue");

    // the back only takes a command the queue holds
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("pop from empty command queue");

    // no result right after reset
    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_out.valid)
        else $error("result valid right after reset");

    // an empty window gives a zero mean
    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.window_count == '0) && (MAX_RADIUS <= 7))
            |-> (o_out.mean_value == '0))
        else $error("nonzero mean with zero count");
`endif

endmodule
